@@ sv/ptw_pkg.sv @@
// Package for the page table map and walk block: field widths, microcode
// field codes, step numbers and the microcode program itself.
// Used by every other file of the block but ptw_store; depends on nothing.
`default_nettype none

package ptw_pkg;

   // Fixed field widths and address slicing.
   localparam int VA_BITS    = 48;
   localparam int PA_BITS    = 40;
   localparam int OUT_BITS   = 40;
   localparam int IDX_BITS   = 9;
   localparam int PAGE_SHIFT = 12;
   localparam int DIR_SHIFT  = 21;
   localparam int PTR_SHIFT  = DIR_SHIFT + IDX_BITS;
   localparam int ROOT_SHIFT = DIR_SHIFT + 2 * IDX_BITS;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int FLAG_BITS  = 3;

   // Entry flag patterns: present and writable for table pointers,
   // present, writable and large for leaf entries.
   localparam logic [FLAG_BITS-1:0] FLAGS_TABLE = 3'b011;
   localparam logic [FLAG_BITS-1:0] FLAGS_LEAF  = 3'b111;

   // Sequencer step numbers.
   typedef logic [3:0] step_type;
   localparam step_type ST_CLEAR   = 4'd0;
   localparam step_type ST_WAIT    = 4'd1;
   localparam step_type ST_RD_ROOT = 4'd2;
   localparam step_type ST_RD_PTR  = 4'd3;
   localparam step_type ST_RD_DIR  = 4'd4;
   localparam step_type ST_LOOKUP  = 4'd5;
   localparam step_type ST_CHECK   = 4'd6;
   localparam step_type ST_WR_ROOT = 4'd7;
   localparam step_type ST_WR_PTR  = 4'd8;
   localparam step_type ST_WR_LEAF = 4'd9;
   localparam step_type ST_FULL    = 4'd10;

   // Microcode fields.
   typedef enum logic [1:0] {RD_NONE, RD_ROOT, RD_PTR, RD_DIR} rd_type;
   typedef enum logic [2:0] {WR_NONE, WR_CLEAR, WR_ROOT, WR_PTR, WR_LEAF} wr_type;
   typedef enum logic [1:0] {CAP_NONE, CAP_ROOT, CAP_PTR} cap_type;
   typedef enum logic [1:0] {RSP_NONE, RSP_LEAF, RSP_OK, RSP_FULL} rsp_type;
   typedef enum logic [2:0] {
      JMP_NEXT, JMP_ALWAYS, JMP_NO_REQ, JMP_MAP, JMP_FULL, JMP_CLR_MORE
   } jump_type;

   // One control word.
   typedef struct packed {
      logic     accept;
      rd_type   rd;
      wr_type   wr;
      cap_type  cap;
      rsp_type  rsp;
      jump_type jmp;
      step_type target;
   } ctl_type;

   // Conditions that the datapath reports to the sequencer.
   typedef struct packed {
      logic req_valid;
      logic map_op;
      logic full;
      logic clr_more;
      logic rsp_busy;
   } cond_type;

   // Operation codes of the request.
   localparam logic OP_MAP    = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // The microcode program, one control word per step.
   function automatic ctl_type ucode(step_type step);
      ctl_type w;
      w = '0;
      case (step)
         ST_CLEAR: begin
            w.wr     = WR_CLEAR;
            w.jmp    = JMP_CLR_MORE;
            w.target = ST_CLEAR;
         end
         ST_WAIT: begin
            w.accept = 1'b1;
            w.jmp    = JMP_NO_REQ;
            w.target = ST_WAIT;
         end
         ST_RD_ROOT: begin
            w.rd = RD_ROOT;
         end
         ST_RD_PTR: begin
            w.cap = CAP_ROOT;
            w.rd  = RD_PTR;
         end
         ST_RD_DIR: begin
            w.cap    = CAP_PTR;
            w.rd     = RD_DIR;
            w.jmp    = JMP_MAP;
            w.target = ST_CHECK;
         end
         ST_LOOKUP: begin
            w.rsp    = RSP_LEAF;
            w.jmp    = JMP_ALWAYS;
            w.target = ST_WAIT;
         end
         ST_CHECK: begin
            w.jmp    = JMP_FULL;
            w.target = ST_FULL;
         end
         ST_WR_ROOT: begin
            w.wr = WR_ROOT;
         end
         ST_WR_PTR: begin
            w.wr = WR_PTR;
         end
         ST_WR_LEAF: begin
            w.wr     = WR_LEAF;
            w.rsp    = RSP_OK;
            w.jmp    = JMP_ALWAYS;
            w.target = ST_WAIT;
         end
         ST_FULL: begin
            w.rsp    = RSP_FULL;
            w.jmp    = JMP_ALWAYS;
            w.target = ST_WAIT;
         end
         default: begin
            w.jmp    = JMP_ALWAYS;
            w.target = ST_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ sv/ptw_req_if.sv @@
// Request channel of the page table block: valid, ready and the request fields.
// Depends on ptw_pkg for the field widths.
`default_nettype none

interface ptw_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [ptw_pkg::VA_BITS-1:0] virt_addr;
   logic [ptw_pkg::PA_BITS-1:0] phys_addr;

   modport source (output valid, op, virt_addr, phys_addr, input ready);
   modport sink   (input valid, op, virt_addr, phys_addr, output ready);
endinterface

`default_nettype wire

@@ sv/ptw_rsp_if.sv @@
// Response channel of the page table block: valid, ready and the result fields.
// Depends on ptw_pkg for the field widths.
`default_nettype none

interface ptw_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ptw_pkg::OUT_BITS-1:0] result_addr;
   logic                         status;

   modport source (output valid, result_addr, status, input ready);
   modport sink   (input valid, result_addr, status, output ready);
endinterface

`default_nettype wire

@@ sv/ptw_store.sv @@
// Table store: single write port, single registered read port.
// Standalone; widths come from the instantiating module.
`default_nettype none

module ptw_store #(
   parameter int DEPTH = 32768,
   parameter int AW    = 15,
   parameter int EW    = 31
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [EW-1:0] wdata,
   input  wire logic          re,
   input  wire logic [AW-1:0] raddr,
   output logic      [EW-1:0] rdata
);

   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rdata_ff;

   // Write and registered read; read data holds between reads.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ sv/ptw_seq.sv @@
// Microcode sequencer: step counter, program table lookup and jump logic.
// Depends on ptw_pkg for the control word, conditions and the program.
`default_nettype none

module ptw_seq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ptw_pkg::cond_type cond,
   output ptw_pkg::ctl_type       ctl
);

   ptw_pkg::step_type step_ff, step_in;
   ptw_pkg::ctl_type  word;
   logic              stall;
   logic              taken;

   // Fetch the control word of the current step.
   assign word = ptw_pkg::ucode(step_ff);

   // A step that loads the response waits while the response slot is full.
   assign stall = (word.rsp != ptw_pkg::RSP_NONE) && cond.rsp_busy;

   // Evaluate the jump condition.
   always_comb begin
      case (word.jmp)
         ptw_pkg::JMP_NEXT:     taken = 1'b0;
         ptw_pkg::JMP_ALWAYS:   taken = 1'b1;
         ptw_pkg::JMP_NO_REQ:   taken = !cond.req_valid;
         ptw_pkg::JMP_MAP:      taken = cond.map_op;
         ptw_pkg::JMP_FULL:     taken = cond.full;
         ptw_pkg::JMP_CLR_MORE: taken = cond.clr_more;
         default:               taken = 1'b0;
      endcase
   end

   // Next step: hold on a stall, otherwise jump or fall through.
   always_comb begin
      if (stall) begin
         step_in = step_ff;
      end else if (taken) begin
         step_in = word.target;
      end else begin
         step_in = step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ptw_pkg::ST_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

   // A stalled step drives no datapath action.
   assign ctl = stall ? '0 : word;

   // After a request is taken the walk always starts with the root read.
   a_accept_to_root: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ptw_pkg::ST_WAIT && cond.req_valid) |=> (step_ff == ptw_pkg::ST_RD_ROOT))
      else $error("walk did not start after request accept");

   // The clearing pass never hands out ready to the request side.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ptw_pkg::ST_CLEAR) |-> !ctl.accept)
      else $error("request accepted during clearing pass");

   // No step is skipped from a leaf write except back to waiting.
   a_leaf_returns: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ptw_pkg::ST_WR_LEAF && !stall) |=> (step_ff == ptw_pkg::ST_WAIT))
      else $error("sequencer left leaf write to an unexpected step");

endmodule

`default_nettype wire

@@ sv/ptw_dpath.sv @@
// Datapath of the page table block: request capture, walk registers, table
// allocation counter, clearing counter, store addressing and response register.
// Depends on ptw_pkg, ptw_req_if, ptw_rsp_if and ptw_store.
`default_nettype none

module ptw_dpath #(
   parameter int NUM_TABLES     = 64,
   parameter int PHYS_ADDR_BITS = 40
) (
   input  wire logic              clock,
   input  wire logic              reset,
   ptw_req_if.sink                req_ch,
   ptw_rsp_if.source              rsp_ch,
   input  wire ptw_pkg::ctl_type  ctl,
   output ptw_pkg::cond_type      cond
);

   localparam int IB    = ptw_pkg::IDX_BITS;
   localparam int TBW   = $clog2(NUM_TABLES);
   localparam int AW    = TBW + IB;
   localparam int DEPTH = NUM_TABLES * ptw_pkg::ENTRIES_PER_TABLE;
   localparam int FB    = PHYS_ADDR_BITS - ptw_pkg::PAGE_SHIFT;
   localparam int FLB   = ptw_pkg::FLAG_BITS;
   localparam int EW    = FB + FLB;
   localparam int NFW   = $clog2(NUM_TABLES + 1);
   localparam int OW    = ptw_pkg::OUT_BITS;
   localparam int PS    = ptw_pkg::PAGE_SHIFT;
   localparam int PAW   = ptw_pkg::PA_BITS;

   // Request capture.
   logic          op_ff;
   logic [IB-1:0] idx_root_ff, idx_ptr_ff, idx_dir_ff;
   logic [FB-1:0] pa_frame_ff;

   // Walk and allocation state.
   logic [TBW-1:0] ptr_tbl_ff, dir_tbl_ff;
   logic           have_ptr_ff, have_dir_ff;
   logic [NFW-1:0] next_free_ff, next_free_in;
   logic [AW-1:0]  clr_ff;

   // Response register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0] rsp_addr_ff;
   logic          rsp_status_ff;
   logic          rsp_load;

   // Store port signals.
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [EW-1:0] mem_wdata, mem_rdata;

   // Decoded read entry.
   logic           e_present, e_valid;
   logic [FB-1:0]  e_frame;
   logic [TBW-1:0] e_tbl;
   logic [PHYS_ADDR_BITS-1:0] leaf_addr;
   logic [TBW-1:0] alloc_tbl;
   logic [1:0]     need;
   logic [NFW-1:0] remaining;

   ptw_store #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .EW    (EW)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Decode the entry that the last read returned; out-of-range tables count as absent.
   assign e_present = mem_rdata[0];
   assign e_frame   = mem_rdata[EW-1:FLB];
   assign e_valid   = e_present && (e_frame < FB'(NUM_TABLES));
   assign e_tbl     = e_valid ? e_frame[TBW-1:0] : '0;
   assign leaf_addr = {e_frame, {PS{1'b0}}};

   // Allocation check: tables needed against tables left.
   assign need      = have_ptr_ff ? (have_dir_ff ? 2'd0 : 2'd1) : 2'd2;
   assign remaining = NFW'(NUM_TABLES) - next_free_ff;
   assign alloc_tbl = TBW'(next_free_ff);

   // Report conditions to the sequencer.
   assign cond.req_valid = req_ch.valid;
   assign cond.map_op    = (op_ff == ptw_pkg::OP_MAP);
   assign cond.full      = NFW'(need) > remaining;
   assign cond.clr_more  = clr_ff != AW'(DEPTH - 1);
   assign cond.rsp_busy  = rsp_valid_ff && !rsp_ch.ready;

   assign req_ch.ready = ctl.accept;

   // Read address selection; lower levels take the table from the entry just read.
   always_comb begin
      mem_re    = 1'b1;
      mem_raddr = '0;
      case (ctl.rd)
         ptw_pkg::RD_ROOT: mem_raddr = {TBW'(0), idx_root_ff};
         ptw_pkg::RD_PTR:  mem_raddr = {e_tbl, idx_ptr_ff};
         ptw_pkg::RD_DIR:  mem_raddr = {e_tbl, idx_dir_ff};
         default:          mem_re    = 1'b0;
      endcase
   end

   // Write selection: clearing pass, table allocation and the leaf entry.
   always_comb begin
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      next_free_in = next_free_ff;
      case (ctl.wr)
         ptw_pkg::WR_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         ptw_pkg::WR_ROOT: begin
            mem_we       = !have_ptr_ff;
            mem_waddr    = {TBW'(0), idx_root_ff};
            mem_wdata    = {FB'(alloc_tbl), ptw_pkg::FLAGS_TABLE};
            next_free_in = have_ptr_ff ? next_free_ff : next_free_ff + NFW'(1);
         end
         ptw_pkg::WR_PTR: begin
            mem_we       = !have_dir_ff;
            mem_waddr    = {ptr_tbl_ff, idx_ptr_ff};
            mem_wdata    = {FB'(alloc_tbl), ptw_pkg::FLAGS_TABLE};
            next_free_in = have_dir_ff ? next_free_ff : next_free_ff + NFW'(1);
         end
         ptw_pkg::WR_LEAF: begin
            mem_we    = 1'b1;
            mem_waddr = {dir_tbl_ff, idx_dir_ff};
            mem_wdata = {pa_frame_ff, ptw_pkg::FLAGS_LEAF};
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Control registers: allocation counter and clearing counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         next_free_ff <= NFW'(1);
         clr_ff       <= '0;
      end else begin
         next_free_ff <= next_free_in;
         if (ctl.wr == ptw_pkg::WR_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
      end
   end

   // Capture the request fields when the request is taken.
   always_ff @(posedge clock) begin
      if (req_ch.valid && ctl.accept) begin
         op_ff       <= req_ch.op;
         idx_root_ff <= req_ch.virt_addr[ptw_pkg::ROOT_SHIFT +: IB];
         idx_ptr_ff  <= req_ch.virt_addr[ptw_pkg::PTR_SHIFT +: IB];
         idx_dir_ff  <= req_ch.virt_addr[ptw_pkg::DIR_SHIFT +: IB];
         pa_frame_ff <= FB'(req_ch.phys_addr[PAW-1:PS]);
      end
   end

   // Walk registers: what each level read found, and tables taken on a map.
   always_ff @(posedge clock) begin
      case (ctl.cap)
         ptw_pkg::CAP_ROOT: begin
            have_ptr_ff <= e_valid;
            ptr_tbl_ff  <= e_tbl;
         end
         ptw_pkg::CAP_PTR: begin
            have_dir_ff <= have_ptr_ff && e_valid;
            dir_tbl_ff  <= e_tbl;
         end
         default: begin
            if (ctl.wr == ptw_pkg::WR_ROOT && !have_ptr_ff) begin
               ptr_tbl_ff <= alloc_tbl;
            end
            if (ctl.wr == ptw_pkg::WR_PTR && !have_dir_ff) begin
               dir_tbl_ff <= alloc_tbl;
            end
         end
      endcase
   end

   // Response register: loaded by the last step of a request, freed on handshake.
   assign rsp_load     = (ctl.rsp != ptw_pkg::RSP_NONE);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         case (ctl.rsp)
            ptw_pkg::RSP_LEAF: begin
               rsp_addr_ff   <= (have_ptr_ff && have_dir_ff) ? OW'(leaf_addr) : '0;
               rsp_status_ff <= 1'b0;
            end
            ptw_pkg::RSP_FULL: begin
               rsp_addr_ff   <= '0;
               rsp_status_ff <= 1'b1;
            end
            default: begin
               rsp_addr_ff   <= '0;
               rsp_status_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_addr = rsp_addr_ff;
   assign rsp_ch.status      = rsp_status_ff;

   // The allocation counter never runs past the number of tables.
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= NFW'(NUM_TABLES))
      else $error("table allocation counter overran the store");

   // A table is only handed out while one is left.
   a_alloc_room: assert property (@(posedge clock) disable iff (reset)
      (next_free_in != next_free_ff) |-> (next_free_ff < NFW'(NUM_TABLES)))
      else $error("table allocated with none left");

   // A new response never overwrites one that is still waiting.
   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(rsp_valid_ff && !rsp_ch.ready))
      else $error("response overwritten before it was taken");

   // Read and write of the store never fall in the same step.
   a_port_split: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("store read and write in the same step");

endmodule

`default_nettype wire

@@ sv/page_table_map_and_walk.sv @@
// Top level of the page table map and walk block.
// Depends on ptw_pkg, ptw_req_if, ptw_rsp_if, ptw_seq and ptw_dpath.
//
//   Channel   Direction  Handshake      Payload
//   req_ch    in         valid / ready  op, virt_addr[47:0], phys_addr[39:0]
//   rsp_ch    out        valid / ready  result_addr[39:0], status
//
// A lookup makes three dependent reads of the single registered-read table store
// and then loads the response register; a map makes the same reads, a check step
// and up to three writes, or answers full when the store has too few tables.
// After reset a clearing pass writes zero to all NUM_TABLES * 512 entries, one a
// cycle, before the first request is accepted.
// A waiting response does not stop the next request from being accepted; only
// the final step of that request holds until the response register is free.
`default_nettype none

module page_table_map_and_walk #(
   parameter int NUM_TABLES     = 64,
   parameter int PHYS_ADDR_BITS = 40
) (
   input  wire logic clock,
   input  wire logic reset,
   ptw_req_if.sink   req_ch,
   ptw_rsp_if.source rsp_ch
);

   ptw_pkg::ctl_type  ctl;
   ptw_pkg::cond_type cond;

   // Microcode sequencer.
   ptw_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctl   (ctl)
   );

   // Datapath with the table store.
   ptw_dpath #(
      .NUM_TABLES     (NUM_TABLES),
      .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .ctl    (ctl),
      .cond   (cond)
   );

endmodule

`default_nettype wire

@@ tb/sv/page_walk_checker.sv @@
`timescale 1ns / 100ps
// Checker for the page table map and walk block: keeps its own copy of the
// table store, predicts every response and compares it with the response channel.
// Depends on ptw_pkg, ptw_req_if and ptw_rsp_if.

module page_walk_checker #(
   parameter int NUM_TABLES     = 64,
   parameter int PHYS_ADDR_BITS = 40
) (
   input  logic clock,
   input  logic reset,
   ptw_req_if   req_ch,
   ptw_rsp_if   rsp_ch,
   output int   failures,
   output int   outstanding,
   output int   full_answers
);

   localparam int FRAME_BITS  = PHYS_ADDR_BITS - ptw_pkg::PAGE_SHIFT;
   localparam int WORD_BITS   = ptw_pkg::FLAG_BITS + FRAME_BITS;
   localparam int STORE_DEPTH = NUM_TABLES * ptw_pkg::ENTRIES_PER_TABLE;
   localparam int PRESENT_BIT = 0;

   typedef logic [WORD_BITS-1:0] pte_type;

   // One predicted response, with the operation kept for the messages.
   typedef struct packed {
      logic                         op;
      logic [ptw_pkg::OUT_BITS-1:0] addr;
      logic                         status;
   } answer_type;

   pte_type     page_store [STORE_DEPTH];
   int unsigned tables_next;
   answer_type  expected_answers[$];

   function automatic int unsigned slot_of(int unsigned tbl,
                                           logic [ptw_pkg::IDX_BITS-1:0] idx);
      return tbl * ptw_pkg::ENTRIES_PER_TABLE + idx;
   endfunction

   // An entry leads to a table only when present and naming a table that exists.
   function automatic bit points_to(pte_type e, output int unsigned tbl);
      logic [FRAME_BITS-1:0] frame;
      frame = e[ptw_pkg::FLAG_BITS +: FRAME_BITS];
      tbl   = 0;
      if (!e[PRESENT_BIT] || frame >= NUM_TABLES) return 1'b0;
      tbl = 32'(frame);
      return 1'b1;
   endfunction

   function automatic pte_type pointer_entry(int unsigned tbl);
      return {FRAME_BITS'(tbl), ptw_pkg::FLAGS_TABLE};
   endfunction

   task automatic wipe_table(int unsigned tbl);
      for (int i = 0; i < ptw_pkg::ENTRIES_PER_TABLE; i++)
         page_store[tbl * ptw_pkg::ENTRIES_PER_TABLE + i] = '0;
   endtask

   // Walk the three levels for one request, updating the store on a map.
   task automatic predict_answer(input logic op, input logic [ptw_pkg::VA_BITS-1:0] va,
                                 input logic [ptw_pkg::PA_BITS-1:0] pa,
                                 output answer_type ans);
      logic [ptw_pkg::IDX_BITS-1:0] i_root, i_ptr, i_dir;
      int unsigned                  ptr_tbl, dir_tbl, need, nf;
      bit                           have_ptr, have_dir;
      logic [FRAME_BITS-1:0]        frame;
      logic [63:0]                  wide;
      i_root     = va[ptw_pkg::ROOT_SHIFT +: ptw_pkg::IDX_BITS];
      i_ptr      = va[ptw_pkg::PTR_SHIFT +: ptw_pkg::IDX_BITS];
      i_dir      = va[ptw_pkg::DIR_SHIFT +: ptw_pkg::IDX_BITS];
      dir_tbl    = 0;
      have_dir   = 1'b0;
      ans.op     = op;
      ans.addr   = '0;
      ans.status = 1'b0;
      have_ptr = points_to(page_store[slot_of(0, i_root)], ptr_tbl);
      if (have_ptr) have_dir = points_to(page_store[slot_of(ptr_tbl, i_ptr)], dir_tbl);
      if (op == ptw_pkg::OP_LOOKUP) begin
         // The leaf's present bit is not tested: an empty leaf reads as zero.
         if (have_ptr && have_dir) begin
            frame    = page_store[slot_of(dir_tbl, i_dir)][ptw_pkg::FLAG_BITS +: FRAME_BITS];
            wide     = 64'(frame) << ptw_pkg::PAGE_SHIFT;
            ans.addr = wide[ptw_pkg::OUT_BITS-1:0];
         end
      end else begin
         // Count the tables needed first; a map that cannot finish writes nothing.
         need = have_ptr ? (have_dir ? 0 : 1) : 2;
         nf   = tables_next;
         if (nf > NUM_TABLES || need > NUM_TABLES - nf) begin
            ans.status = 1'b1;
         end else begin
            if (!have_ptr) begin
               ptr_tbl = nf;
               nf++;
               wipe_table(ptr_tbl);
               page_store[slot_of(0, i_root)] = pointer_entry(ptr_tbl);
            end
            if (!have_dir) begin
               dir_tbl = nf;
               nf++;
               wipe_table(dir_tbl);
               page_store[slot_of(ptr_tbl, i_ptr)] = pointer_entry(dir_tbl);
            end
            tables_next = nf;
            frame = FRAME_BITS'(pa >> ptw_pkg::PAGE_SHIFT);
            page_store[slot_of(dir_tbl, i_dir)] = {frame, ptw_pkg::FLAGS_LEAF};
         end
      end
   endtask

   // Compare each response with the oldest prediction, then predict new requests.
   always @(posedge clock) begin
      answer_type want, fresh;
      int         errs;
      errs = 0;
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) page_store[i] = '0;
         tables_next = 1;
         expected_answers.delete();
         failures     <= 0;
         full_answers <= 0;
         outstanding  <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_answers.size() == 0) begin
               $display("%0t: response with nothing expected: result_addr %h status %b",
                        $time, rsp_ch.result_addr, rsp_ch.status);
               errs++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_ch.result_addr !== want.addr) begin
                  $display("%0t: %s result_addr mismatch: expected %h, got %h", $time,
                           (want.op == ptw_pkg::OP_MAP) ? "map" : "lookup", want.addr,
                           rsp_ch.result_addr);
                  errs++;
               end
               if (rsp_ch.status !== want.status) begin
                  $display("%0t: %s status mismatch: expected %b, got %b", $time,
                           (want.op == ptw_pkg::OP_MAP) ? "map" : "lookup", want.status,
                           rsp_ch.status);
                  errs++;
               end
               if (want.status) full_answers <= full_answers + 1;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_answer(req_ch.op, req_ch.virt_addr, req_ch.phys_addr, fresh);
            expected_answers.push_back(fresh);
         end
         failures    <= failures + errs;
         outstanding <= expected_answers.size();
      end
   end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Top of the page table testbench: clock, reset, request and response traffic,
// and the verdict. Depends on ptw_pkg, both channel interfaces, the block and
// page_walk_checker.

module testbench;

   localparam int NUM_TABLES     = 64;
   localparam int PHYS_ADDR_BITS = 40;
   localparam int RANDOM_ITEMS   = 1000;
   localparam int HOLD_AFTER     = 400;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 24;

   logic clock;
   logic reset;
   int   failures, outstanding, full_answers;
   int   maps_sent, lookups_sent, items_sent, answers_taken;
   logic [ptw_pkg::VA_BITS-1:0] known_va[$];

   ptw_req_if req_ch ();
   ptw_rsp_if rsp_ch ();

   page_table_map_and_walk #(
      .NUM_TABLES     (NUM_TABLES),
      .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   page_walk_checker #(
      .NUM_TABLES     (NUM_TABLES),
      .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
   ) walk_check (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .failures     (failures),
      .outstanding  (outstanding),
      .full_answers (full_answers)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The run ends here if the block stops answering.
   initial begin
      #1000000;
      $display("FAIL");
      $finish;
   end

   // Offer one request after a random gap and hold it until it is taken.
   // A stretch of items in the middle goes without gaps.
   task automatic send_request(logic op, logic [ptw_pkg::VA_BITS-1:0] va,
                               logic [ptw_pkg::PA_BITS-1:0] pa);
      int gap;
      gap = (items_sent >= 600 && items_sent < 750) ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.op        <= op;
      req_ch.virt_addr <= va;
      req_ch.phys_addr <= pa;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      if (op == ptw_pkg::OP_MAP) begin
         maps_sent++;
         known_va.push_back(va);
      end else begin
         lookups_sent++;
      end
   endtask

   // Response side: random stalls, one long hold that backs the block up,
   // and a stretch with no stalls.
   initial begin
      int gap;
      answers_taken = 0;
      rsp_ch.ready  = 1'b0;
      @(negedge reset);
      forever begin
         if (answers_taken == HOLD_AFTER) gap = HOLD_CYCLES;
         else if (answers_taken >= 750 && answers_taken < 950) gap = 0;
         else gap = $urandom_range(0, 7);
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         answers_taken++;
      end
   end

   // Request side: directed cases, then random traffic, then the verdict.
   initial begin
      logic [ptw_pkg::VA_BITS-1:0] va, base;
      logic [ptw_pkg::PA_BITS-1:0] pa;
      logic                        op;
      int                          kind;
      maps_sent        = 0;
      lookups_sent     = 0;
      items_sent       = 0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.op        = ptw_pkg::OP_MAP;
      req_ch.virt_addr = '0;
      req_ch.phys_addr = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty root, first map, both address extremes, then an unmapped leaf
      // under present tables, an absent pointer entry and a remap.
      send_request(ptw_pkg::OP_LOOKUP, '0, '0);
      send_request(ptw_pkg::OP_MAP, '0, '0);
      send_request(ptw_pkg::OP_LOOKUP, '0, '1);
      send_request(ptw_pkg::OP_MAP, '1, '1);
      send_request(ptw_pkg::OP_LOOKUP, '1, '0);
      send_request(ptw_pkg::OP_LOOKUP, {9'h1ff, 9'h1ff, 9'h000, 21'h1fffff}, '0);
      send_request(ptw_pkg::OP_LOOKUP, {9'h1ff, 9'h000, 9'h1ff, 21'h000000}, '0);
      send_request(ptw_pkg::OP_MAP, {9'h1ff, 9'h000, 9'h1ff, 21'h000000},
                   40'h12_3456_7abc);
      send_request(ptw_pkg::OP_LOOKUP, {9'h1ff, 9'h000, 9'h1ff, 21'h1fffff}, '0);
      send_request(ptw_pkg::OP_MAP, '1, 40'h80_0000_1000);
      send_request(ptw_pkg::OP_LOOKUP, '1, '0);
      send_request(ptw_pkg::OP_MAP, {9'h000, 9'h000, 9'h1ff, 21'h000000},
                   40'haa_aaaa_afff);
      send_request(ptw_pkg::OP_LOOKUP, {9'h000, 9'h000, 9'h1ff, 21'h0f0f0f}, '0);
      send_request(ptw_pkg::OP_MAP, {9'h155, 9'h0aa, 9'h155, 21'h0aaaaa},
                   40'h55_5555_5555);
      send_request(ptw_pkg::OP_LOOKUP, {9'h155, 9'h0aa, 9'h155, 21'h155555}, '0);
      send_request(ptw_pkg::OP_LOOKUP, {9'h0aa, 9'h155, 9'h0aa, 21'h0aaaaa}, '0);
      send_request(ptw_pkg::OP_MAP, {9'h0aa, 9'h155, 9'h0aa, 21'h155555},
                   40'h00_0000_0fff);

      // Random traffic: mostly addresses that share a path with earlier maps,
      // some new paths that consume tables until the store runs out.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         va   = ptw_pkg::VA_BITS'({$urandom, $urandom});
         pa   = ptw_pkg::PA_BITS'({$urandom, $urandom});
         op   = ($urandom_range(0, 99) < 45) ? ptw_pkg::OP_MAP : ptw_pkg::OP_LOOKUP;
         base = known_va[$urandom_range(0, known_va.size() - 1)];
         kind = $urandom_range(0, 99);
         if (kind >= 60)
            va[ptw_pkg::VA_BITS-1:ptw_pkg::DIR_SHIFT] =
               base[ptw_pkg::VA_BITS-1:ptw_pkg::DIR_SHIFT];
         else if (kind >= 20)
            va[ptw_pkg::VA_BITS-1:ptw_pkg::PTR_SHIFT] =
               base[ptw_pkg::VA_BITS-1:ptw_pkg::PTR_SHIFT];
         else if (kind >= 10)
            va[ptw_pkg::VA_BITS-1:ptw_pkg::ROOT_SHIFT] =
               base[ptw_pkg::VA_BITS-1:ptw_pkg::ROOT_SHIFT];
         send_request(op, va, pa);
      end
      req_ch.valid <= 1'b0;

      // Drain, then allow for a map still in flight.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d map and %0d lookup requests, %0d of them answered store full,",
               maps_sent, lookups_sent, full_answers);
      $display("with random stalls on both sides and one long response hold.");
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/ptw_pkg.sv
sv/ptw_req_if.sv
sv/ptw_rsp_if.sv
sv/ptw_store.sv
sv/ptw_seq.sv
sv/ptw_dpath.sv
sv/page_table_map_and_walk.sv
tb/sv/page_walk_checker.sv
tb/sv/testbench.sv
